[hw/rtl/sine_phase_accumulator_generator_macros.svh]
// Assertion macros shared by the sine phase accumulator generator RTL.
`ifndef SINE_PHASE_ACCUMULATOR_GENERATOR_MACROS_SVH
`define SINE_PHASE_ACCUMULATOR_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPAG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/spag_pkg.sv]
// Package: widths, register map and quarter-wave sine table for the sine generator.
package spag_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SINE_BITS       = 16;

	localparam int STEP_W = 32;
	localparam int MV_W   = 12;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Quarter-wave table geometry
	localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
	localparam int QUARTER      = 1 << QUARTER_BITS;
	localparam int MAG_W        = SINE_BITS - 1;
	localparam logic [MAG_W-1:0] SINE_SCALE = {MAG_W{1'b1}};
	localparam logic [MV_W-1:0]  MV_MAX     = {MV_W{1'b1}};

	// Register indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_AMPLITUDE  = 2'd1,
		REG_OFFSET     = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	// Odd polynomial coefficients of sin(pi/2 * u) in Q30
	localparam logic [63:0] C1  = 64'd1686629713;
	localparam logic [63:0] C3  = 64'd693598669;
	localparam logic [63:0] C5  = 64'd85569306;
	localparam logic [63:0] C7  = 64'd5026995;
	localparam logic [63:0] C9  = 64'd172272;
	localparam logic [63:0] C11 = 64'd3865;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef logic [QUARTER-1:0][MAG_W-1:0] quarter_tbl_t;

	// Quarter-turn sine in Q30, each product truncated
	function automatic logic [63:0] quarter_sine(input logic [63:0] u);
		logic [63:0] u2;
		logic [63:0] p;
		u2 = (u * u) >> 30;
		p  = C9 - ((u2 * C11) >> 30);
		p  = C7 - ((u2 * p) >> 30);
		p  = C5 - ((u2 * p) >> 30);
		p  = C3 - ((u2 * p) >> 30);
		p  = C1 - ((u2 * p) >> 30);
		p  = (u * p) >> 30;
		if (p > Q30_ONE) p = Q30_ONE;
		return p;
	endfunction

	// Build magnitudes for the first quarter turn at elaboration
	function automatic quarter_tbl_t build_quarter_table();
		quarter_tbl_t tbl;
		logic [63:0]  s;
		logic [63:0]  mag;
		for (int i = 0; i < QUARTER; i++) begin
			s   = quarter_sine(64'(i) << (32 - TABLE_ADDR_BITS));
			mag = (s * 64'(SINE_SCALE) + (64'd1 << 29)) >> 30;
			if (mag > 64'(SINE_SCALE)) mag = 64'(SINE_SCALE);
			tbl[i] = mag[MAG_W-1:0];
		end
		return tbl;
	endfunction

	localparam quarter_tbl_t QUARTER_TABLE = build_quarter_table();

endpackage

[hw/rtl/sine_phase_accumulator_generator.sv]
// Direct digital synthesis sine generator: phase accumulator, sine lookup and scaling.
//
// Request channel (req_valid/req_ready) carries one word holding sample_tick.
// A word with sample_tick high reads the current phase, produces one sample on
// the result channel (rsp_valid/rsp_ready: sample_mv, phase_index) and then
// advances the phase by phase_step. A word with sample_tick low is taken and
// dropped without effect.
// The index register holds an accepted word while lookup and scaling run,
// and the output register then loads the result word.
// Throughput: one word per cycle unless the result receiver stalls; the phase
// add runs in the accept cycle and the table read plus one 13x16 multiply-add
// fill the second stage.
// Stall: when the result receiver holds rsp_ready low, the output register
// keeps its word, the index stage fills, and then req_ready drops until the
// result is taken. No word is lost or repeated.
// Reset: phase returns to zero, registers to phase_step 143165577,
// amplitude_mv 1000, offset_mv 2000, and both stages empty.
// APB port: phase_step at 0x0, amplitude_mv at 0x4, offset_mv at 0x8; write
// only while no request is in flight.
module sine_phase_accumulator_generator
	import spag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// request channel
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              sample_tick,
	// result channel
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [MV_W-1:0]   sample_mv,
	output logic [TABLE_ADDR_BITS-1:0] phase_index
);

`include "sine_phase_accumulator_generator_macros.svh"

	localparam int PROD_W = MV_W + 1 + SINE_BITS;
	localparam int SUM_W  = PROD_W + 1;

	logic [STEP_W-1:0]     phase_step_q;
	logic [MV_W-1:0]       amplitude_q;
	logic [MV_W-1:0]       offset_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] step_ext;

	logic                       valid_s1;
	logic [TABLE_ADDR_BITS-1:0] idx_s1;
	logic                       valid_s2;
	logic [MV_W-1:0]            sample_s2;
	logic [TABLE_ADDR_BITS-1:0] index_s2;

	logic                       cfg_wr;
	reg_idx_t                   cfg_idx;
	logic                       adv_s1;
	logic                       take_tick;
	logic [TABLE_ADDR_BITS-1:0] idx_now;

	logic [1:0]                 quad;
	logic [QUARTER_BITS:0]      kq;
	logic [MAG_W-1:0]           mag;
	logic signed [SINE_BITS-1:0] sine;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SUM_W-1:0]    sum;
	logic [MV_W-1:0]            sample_sat;

	// Decode the APB access
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_PHASE_STEP: prdata = DATA_W'(phase_step_q);
			REG_AMPLITUDE:  prdata = DATA_W'(amplitude_q);
			REG_OFFSET:     prdata = DATA_W'(offset_q);
			default:        prdata = '0;
		endcase
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= STEP_W'(143165577);
			amplitude_q  <= MV_W'(1000);
			offset_q     <= MV_W'(2000);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PHASE_STEP: phase_step_q <= pwdata[STEP_W-1:0];
				REG_AMPLITUDE:  amplitude_q  <= pwdata[MV_W-1:0];
				REG_OFFSET:     offset_q     <= pwdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign adv_s1    = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || adv_s1;
	assign take_tick = req_valid && req_ready && sample_tick;
	assign step_ext  = PHASE_BITS'(phase_step_q);
	assign idx_now   = phase_acc_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];

	// Advance the phase on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (take_tick) begin
			phase_acc_q <= phase_acc_q + step_ext;
		end
	end

	// Stage 1: capture the table index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid && sample_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			idx_s1 <= idx_now;
		end
	end

	// Mirror into the first quarter and look up the magnitude
	always_comb begin
		quad = idx_s1[TABLE_ADDR_BITS-1 -: 2];
		if (quad[0]) begin
			kq = (QUARTER_BITS+1)'(QUARTER) - {1'b0, idx_s1[QUARTER_BITS-1:0]};
		end else begin
			kq = {1'b0, idx_s1[QUARTER_BITS-1:0]};
		end
		mag  = kq[QUARTER_BITS] ? SINE_SCALE : QUARTER_TABLE[kq[QUARTER_BITS-1:0]];
		sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	// Scale, offset and saturate
	always_comb begin
		prod = $signed({1'b0, amplitude_q}) * sine;
		sum  = $signed({{(SUM_W-MV_W){1'b0}}, offset_q})
			+ SUM_W'(prod >>> (SINE_BITS - 1));
		if (sum < 0) begin
			sample_sat = '0;
		end else if (sum > $signed(SUM_W'(MV_MAX))) begin
			sample_sat = MV_MAX;
		end else begin
			sample_sat = sum[MV_W-1:0];
		end
	end

	// Stage 2: output register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			sample_s2 <= sample_sat;
			index_s2  <= idx_s1;
		end
	end

	assign rsp_valid   = valid_s2;
	assign sample_mv   = sample_s2;
	assign phase_index = index_s2;

	// Checks
	`SPAG_ASSERT_NEXT(a_phase_hold, !take_tick, $stable(phase_acc_q),
		"phase moved without an accepted tick")
	`SPAG_ASSERT_NEXT(a_phase_step, take_tick,
		phase_acc_q == PHASE_BITS'($past(phase_acc_q) + $past(step_ext)),
		"phase did not advance by phase_step")
	`SPAG_ASSERT_NEXT(a_index_capture, take_tick,
		valid_s1 && idx_s1 == $past(idx_now),
		"accepted tick did not load the index stage")
	`SPAG_ASSERT_NOW(a_full_stall, valid_s1 && valid_s2 && !rsp_ready, !req_ready,
		"request taken while both stages are stalled")

endmodule
